[hw/rtl/trapezoid_exp_integrator_top_defines.svh]
// Assertion macros for the integrator RTL, used by tei_ctrl.
// Each expects i_clk and i_rst_n in the scope where it is used.
`ifndef TRAPEZOID_EXP_INTEGRATOR_TOP_DEFINES_SVH
`define TRAPEZOID_EXP_INTEGRATOR_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define TEI_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define TEI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TEI_ASSERT_IMP(label, ante, cons, msg)
`define TEI_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

[hw/rtl/tei_pkg.sv]
package tei_pkg;

    localparam int FRAC_BITS         = 16;
    localparam int IN_W              = 20;
    localparam int N_W               = 13;
    localparam int OUT_W             = 29;
    localparam int MAX_INTERVALS_DEF = 4096;
    localparam int EXP_W             = 29;
    localparam int S2_W              = 43;
    localparam int DM_W              = 20;
    localparam int PROD_W            = S2_W + DM_W;
    localparam int RED_W             = 38;
    localparam int K_W               = 6;
    localparam int TAYLOR_TERMS      = 15;
    localparam int RECIP_SHIFT       = 36;
    localparam int RECIP_W           = 37;

    localparam logic [31:0]        LN2_Q32  = 32'd2977044472;
    // offset that makes x*2^16 non-negative before the ln2 search (12 * ln2)
    localparam logic [RED_W-1:0]   RED_INIT = 38'd35724533664;
    localparam logic signed [K_W-1:0] K_MIN = -6'sd12;

    typedef struct packed {
        logic signed [IN_W-1:0] lower_bound;
        logic signed [IN_W-1:0] upper_bound;
        logic [N_W-1:0]         intervals;
    } t_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] integral;
        logic                    saturated;
    } t_out;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_RANGE,
        ST_WAIT_RANGE,
        ST_EXP_A,
        ST_WAIT_A,
        ST_EXP_B,
        ST_WAIT_B,
        ST_CHECK,
        ST_STEP,
        ST_EXP_X,
        ST_WAIT_X,
        ST_MUL,
        ST_WAIT_MUL,
        ST_DIV_SUM,
        ST_WAIT_SUM,
        ST_FINISH
    } t_state;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RANGE,
        PH_MUL,
        PH_RECIP,
        PH_CORR,
        PH_SHIFT
    } t_exp_phase;

    typedef enum logic [1:0] {
        SEL_A,
        SEL_B,
        SEL_X
    } t_exp_sel;

    typedef struct packed {
        logic     load;
        logic     div_start;
        logic     div_sum;
        logic     latch_range;
        logic     exp_start;
        t_exp_sel exp_sel;
        logic     accum;
        logic     accum_double;
        logic     grid_step;
        logic     mul_start;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic exp_done;
        logic mul_done;
        logic grid_last;
        logic out_free;
    } t_status;

    // floor(2^36 / i) for the Taylor term divisors
    function automatic logic [RECIP_W-1:0] recip(input logic [3:0] idx);
        logic [RECIP_W-1:0] val;
        unique case (idx)
            4'd1:    val = 37'd68719476736;
            4'd2:    val = 37'd34359738368;
            4'd3:    val = 37'd22906492245;
            4'd4:    val = 37'd17179869184;
            4'd5:    val = 37'd13743895347;
            4'd6:    val = 37'd11453246122;
            4'd7:    val = 37'd9817068105;
            4'd8:    val = 37'd8589934592;
            4'd9:    val = 37'd7635497415;
            4'd10:   val = 37'd6871947673;
            4'd11:   val = 37'd6247225157;
            4'd12:   val = 37'd5726623061;
            4'd13:   val = 37'd5286113595;
            4'd14:   val = 37'd4908534052;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

[hw/rtl/tei_div.sv]
// Restoring divider, one quotient bit per cycle.
module tei_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [tei_pkg::PROD_W-1:0]      i_dividend,
    input  logic [tei_pkg::N_W-1:0]         i_divisor,
    output logic [tei_pkg::PROD_W-1:0]      o_quotient,
    output logic [tei_pkg::N_W-1:0]         o_remainder,
    output logic                            o_done
);
    localparam int CNT_W = $clog2(tei_pkg::PROD_W);

    logic [tei_pkg::PROD_W-1:0] r_dvd, n_dvd;
    logic [tei_pkg::N_W-1:0]    r_rem, n_rem;
    logic [CNT_W-1:0]           r_cnt, n_cnt;
    logic                       r_busy, n_busy;
    logic                       r_done, n_done;
    logic [tei_pkg::N_W:0]      trial;
    logic                       qbit;

    always_comb begin
        trial = {r_rem, r_dvd[tei_pkg::PROD_W-1]};
        qbit  = (trial >= {1'b0, i_divisor});
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (r_busy) begin
            n_dvd = {r_dvd[tei_pkg::PROD_W-2:0], qbit};
            n_rem = qbit ? tei_pkg::N_W'(trial - {1'b0, i_divisor})
                         : tei_pkg::N_W'(trial);
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(tei_pkg::PROD_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else if (i_start) begin
            n_dvd  = i_dividend;
            n_rem  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_rem <= n_rem;
    end

    assign o_quotient  = r_dvd;
    assign o_remainder = r_rem;
    assign o_done      = r_done;

endmodule

[hw/rtl/tei_exp.sv]
// Fixed-point exp: ln2 range reduction by repeated subtraction, 15-term
// Taylor sum in Q.32, then a rounding shift to FRAC_BITS. For 20-bit Q4.16
// inputs the shift is always 5..28 right, so the result always fits in EXP_W bits.
module tei_exp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [tei_pkg::IN_W-1:0]    i_x,
    output logic [tei_pkg::EXP_W-1:0]          o_value,
    output logic                               o_done
);
    tei_pkg::t_exp_phase            r_phase, n_phase;
    logic [tei_pkg::RED_W-1:0]      r_red;
    logic signed [tei_pkg::K_W-1:0] r_k;
    logic [32:0]                    r_term;
    logic [33:0]                    r_sum;
    logic [31:0]                    r_p;
    logic [68:0]                    r_pm;
    logic [3:0]                     r_idx;
    logic [tei_pkg::EXP_W-1:0]      r_value;
    logic                           r_done;

    logic [tei_pkg::RED_W-1:0] xw;
    logic [64:0]               prod;
    logic [31:0]               q0, qc;
    logic [35:0]               back, rem;
    logic signed [6:0]         shift_s;
    logic [4:0]                sh;
    logic [34:0]               rounded;

    always_comb begin
        xw      = {{2{i_x[tei_pkg::IN_W-1]}}, i_x, 16'b0};
        prod    = 65'(r_term) * 65'(r_red[31:0]);
        q0      = r_pm[67:36];
        back    = 36'(q0) * 36'(r_idx);
        rem     = {4'b0, r_p} - back;
        qc      = (rem >= 36'(r_idx)) ? q0 + 32'd1 : q0;
        shift_s = 7'sd16 - 7'(r_k);
        sh      = shift_s[4:0];
        rounded = (35'(r_sum) + (35'd1 << (sh - 5'd1))) >> sh;
    end

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            tei_pkg::PH_IDLE:  if (i_start) n_phase = tei_pkg::PH_RANGE;
            tei_pkg::PH_RANGE: if (r_red < 38'(tei_pkg::LN2_Q32)) n_phase = tei_pkg::PH_MUL;
            tei_pkg::PH_MUL:   n_phase = tei_pkg::PH_RECIP;
            tei_pkg::PH_RECIP: n_phase = tei_pkg::PH_CORR;
            tei_pkg::PH_CORR: begin
                if (r_idx == 4'(tei_pkg::TAYLOR_TERMS - 1)) n_phase = tei_pkg::PH_SHIFT;
                else n_phase = tei_pkg::PH_MUL;
            end
            tei_pkg::PH_SHIFT: n_phase = tei_pkg::PH_IDLE;
            default:           n_phase = tei_pkg::PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= tei_pkg::PH_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= (r_phase == tei_pkg::PH_SHIFT);
        end
        unique case (r_phase)
            tei_pkg::PH_IDLE: begin
                r_red <= xw + tei_pkg::RED_INIT;
                r_k   <= tei_pkg::K_MIN;
            end
            tei_pkg::PH_RANGE: begin
                if (r_red >= 38'(tei_pkg::LN2_Q32)) begin
                    r_red <= r_red - 38'(tei_pkg::LN2_Q32);
                    r_k   <= r_k + tei_pkg::K_W'(1);
                end else begin
                    r_term <= 33'h1_0000_0000;
                    r_sum  <= 34'h1_0000_0000;
                    r_idx  <= 4'd1;
                end
            end
            tei_pkg::PH_MUL:   r_p  <= prod[63:32];
            tei_pkg::PH_RECIP: r_pm <= 69'(r_p) * 69'(tei_pkg::recip(r_idx));
            tei_pkg::PH_CORR: begin
                r_term <= {1'b0, qc};
                r_sum  <= r_sum + 34'(qc);
                r_idx  <= r_idx + 4'd1;
            end
            tei_pkg::PH_SHIFT: r_value <= tei_pkg::EXP_W'(rounded);
            default: ;
        endcase
    end

    assign o_value = r_value;
    assign o_done  = r_done;

endmodule

[hw/rtl/tei_dp.sv]
module tei_dp #(
    parameter int MAX_INTERVALS = tei_pkg::MAX_INTERVALS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tei_pkg::t_cmd    i_cmd,
    input  tei_pkg::t_in     i_in_data,
    output tei_pkg::t_status o_status,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output tei_pkg::t_out    o_out_data
);
    localparam int MUL_CNT_W = $clog2(tei_pkg::DM_W);

    logic signed [tei_pkg::IN_W-1:0] r_a, r_b, r_x;
    logic [tei_pkg::N_W-1:0]         r_n, r_r0, r_grem, r_idx;
    logic                            r_neg;
    logic [tei_pkg::DM_W-1:0]        r_dm, r_q0, r_gq;
    logic [tei_pkg::S2_W-1:0]        r_s2;
    logic [tei_pkg::PROD_W-1:0]      r_macc, r_mcand;
    logic [tei_pkg::DM_W-1:0]        r_mplier;
    logic [MUL_CNT_W-1:0]            r_mcnt;
    logic                            r_mul_busy, r_mul_done;
    tei_pkg::t_out                   r_out;
    logic                            r_out_valid;

    logic signed [tei_pkg::IN_W:0]   d;
    logic [tei_pkg::N_W-1:0]         n_clip;
    logic [tei_pkg::N_W:0]           rem_sum;
    logic                            wrap;
    logic [tei_pkg::DM_W-1:0]        n_gq;
    logic [tei_pkg::IN_W:0]          x_wide;
    logic signed [tei_pkg::IN_W-1:0] exp_x;
    logic [tei_pkg::EXP_W-1:0]       exp_val;
    logic                            exp_done;
    logic [tei_pkg::PROD_W-1:0]      div_quo;
    logic [tei_pkg::N_W-1:0]         div_rem;
    logic                            div_done;
    logic [tei_pkg::PROD_W:0]        t_round;
    logic [46:0]                     mag;
    tei_pkg::t_out                   res;

    always_comb begin
        d = {i_in_data.upper_bound[tei_pkg::IN_W-1], i_in_data.upper_bound}
          - {i_in_data.lower_bound[tei_pkg::IN_W-1], i_in_data.lower_bound};
        if (i_in_data.intervals == '0) begin
            n_clip = tei_pkg::N_W'(1);
        end else if (17'(i_in_data.intervals) > 17'(MAX_INTERVALS)) begin
            n_clip = tei_pkg::N_W'(MAX_INTERVALS);
        end else begin
            n_clip = i_in_data.intervals;
        end
    end

    // grid point i: floor(i*|d|/n) kept as quotient plus remainder
    always_comb begin
        rem_sum = {1'b0, r_grem} + {1'b0, r_r0};
        wrap    = (rem_sum >= {1'b0, r_n});
        n_gq    = r_gq + r_q0 + tei_pkg::DM_W'(wrap);
        x_wide  = r_neg ? {r_a[tei_pkg::IN_W-1], r_a} - {1'b0, n_gq}
                        : {r_a[tei_pkg::IN_W-1], r_a} + {1'b0, n_gq};
    end

    always_comb begin
        unique case (i_cmd.exp_sel)
            tei_pkg::SEL_A: exp_x = r_a;
            tei_pkg::SEL_B: exp_x = r_b;
            tei_pkg::SEL_X: exp_x = r_x;
            default:        exp_x = r_x;
        endcase
    end

    tei_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.exp_start),
        .i_x     (exp_x),
        .o_value (exp_val),
        .o_done  (exp_done)
    );

    tei_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (i_cmd.div_sum ? r_macc : tei_pkg::PROD_W'(r_dm)),
        .i_divisor   (r_n),
        .o_quotient  (div_quo),
        .o_remainder (div_rem),
        .o_done      (div_done)
    );

    always_comb begin
        t_round = {1'b0, div_quo} + (64'd1 << tei_pkg::FRAC_BITS);
        mag     = t_round[tei_pkg::PROD_W:tei_pkg::FRAC_BITS+1];
        if (r_neg) begin
            if (mag > 47'h1000_0000) begin
                res.integral  = 29'sh1000_0000;
                res.saturated = 1'b1;
            end else begin
                res.integral  = 29'(29'd0 - mag[28:0]);
                res.saturated = 1'b0;
            end
        end else begin
            if (mag > 47'h0FFF_FFFF) begin
                res.integral  = 29'sh0FFF_FFFF;
                res.saturated = 1'b1;
            end else begin
                res.integral  = 29'(mag[28:0]);
                res.saturated = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a    <= i_in_data.lower_bound;
            r_b    <= i_in_data.upper_bound;
            r_n    <= n_clip;
            r_neg  <= d[tei_pkg::IN_W];
            r_dm   <= d[tei_pkg::IN_W] ? tei_pkg::DM_W'(-d) : tei_pkg::DM_W'(d);
            r_s2   <= '0;
            r_gq   <= '0;
            r_grem <= '0;
            r_idx  <= '0;
        end
        if (i_cmd.latch_range) begin
            r_q0 <= div_quo[tei_pkg::DM_W-1:0];
            r_r0 <= div_rem;
        end
        if (i_cmd.grid_step) begin
            r_gq   <= n_gq;
            r_grem <= wrap ? tei_pkg::N_W'(rem_sum - {1'b0, r_n}) : rem_sum[tei_pkg::N_W-1:0];
            r_idx  <= r_idx + 1'b1;
            r_x    <= x_wide[tei_pkg::IN_W-1:0];
        end
        if (i_cmd.accum) begin
            r_s2 <= r_s2 + (i_cmd.accum_double ? tei_pkg::S2_W'({exp_val, 1'b0})
                                               : tei_pkg::S2_W'(exp_val));
        end
        // shift-add multiply s2 * |d|, one multiplier bit per cycle
        if (i_cmd.mul_start) begin
            r_macc   <= '0;
            r_mcand  <= tei_pkg::PROD_W'(r_s2);
            r_mplier <= r_dm;
            r_mcnt   <= '0;
        end else if (r_mul_busy) begin
            if (r_mplier[0]) r_macc <= r_macc + r_mcand;
            r_mcand  <= r_mcand << 1;
            r_mplier <= r_mplier >> 1;
            r_mcnt   <= r_mcnt + 1'b1;
        end
        if (i_cmd.out_load) r_out <= res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_busy  <= 1'b0;
            r_mul_done  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mul_done <= 1'b0;
            if (i_cmd.mul_start) begin
                r_mul_busy <= 1'b1;
            end else if (r_mul_busy && r_mcnt == MUL_CNT_W'(tei_pkg::DM_W - 1)) begin
                r_mul_busy <= 1'b0;
                r_mul_done <= 1'b1;
            end
            if (i_cmd.out_load) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        o_status.div_done  = div_done;
        o_status.exp_done  = exp_done;
        o_status.mul_done  = r_mul_done;
        o_status.grid_last = (r_idx == r_n - 1'b1);
        o_status.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[hw/rtl/tei_ctrl.sv]
`include "trapezoid_exp_integrator_top_defines.svh"

module tei_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  tei_pkg::t_status i_status,
    output tei_pkg::t_cmd    o_cmd
);
    tei_pkg::t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tei_pkg::ST_IDLE:       if (i_in_valid) n_state = tei_pkg::ST_DIV_RANGE;
            tei_pkg::ST_DIV_RANGE:  n_state = tei_pkg::ST_WAIT_RANGE;
            tei_pkg::ST_WAIT_RANGE: if (i_status.div_done) n_state = tei_pkg::ST_EXP_A;
            tei_pkg::ST_EXP_A:      n_state = tei_pkg::ST_WAIT_A;
            tei_pkg::ST_WAIT_A:     if (i_status.exp_done) n_state = tei_pkg::ST_EXP_B;
            tei_pkg::ST_EXP_B:      n_state = tei_pkg::ST_WAIT_B;
            tei_pkg::ST_WAIT_B:     if (i_status.exp_done) n_state = tei_pkg::ST_CHECK;
            tei_pkg::ST_CHECK: begin
                if (i_status.grid_last) n_state = tei_pkg::ST_MUL;
                else n_state = tei_pkg::ST_STEP;
            end
            tei_pkg::ST_STEP:       n_state = tei_pkg::ST_EXP_X;
            tei_pkg::ST_EXP_X:      n_state = tei_pkg::ST_WAIT_X;
            tei_pkg::ST_WAIT_X:     if (i_status.exp_done) n_state = tei_pkg::ST_CHECK;
            tei_pkg::ST_MUL:        n_state = tei_pkg::ST_WAIT_MUL;
            tei_pkg::ST_WAIT_MUL:   if (i_status.mul_done) n_state = tei_pkg::ST_DIV_SUM;
            tei_pkg::ST_DIV_SUM:    n_state = tei_pkg::ST_WAIT_SUM;
            tei_pkg::ST_WAIT_SUM:   if (i_status.div_done) n_state = tei_pkg::ST_FINISH;
            tei_pkg::ST_FINISH:     if (i_status.out_free) n_state = tei_pkg::ST_IDLE;
            default:                n_state = tei_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.exp_sel = tei_pkg::SEL_X;
        o_in_ready    = (r_state == tei_pkg::ST_IDLE);
        unique case (r_state)
            tei_pkg::ST_IDLE:       o_cmd.load = i_in_valid;
            tei_pkg::ST_DIV_RANGE:  o_cmd.div_start = 1'b1;
            tei_pkg::ST_WAIT_RANGE: o_cmd.latch_range = i_status.div_done;
            tei_pkg::ST_EXP_A: begin
                o_cmd.exp_start = 1'b1;
                o_cmd.exp_sel   = tei_pkg::SEL_A;
            end
            tei_pkg::ST_WAIT_A:     o_cmd.accum = i_status.exp_done;
            tei_pkg::ST_EXP_B: begin
                o_cmd.exp_start = 1'b1;
                o_cmd.exp_sel   = tei_pkg::SEL_B;
            end
            tei_pkg::ST_WAIT_B:     o_cmd.accum = i_status.exp_done;
            tei_pkg::ST_CHECK:      ;
            tei_pkg::ST_STEP:       o_cmd.grid_step = 1'b1;
            tei_pkg::ST_EXP_X:      o_cmd.exp_start = 1'b1;
            tei_pkg::ST_WAIT_X: begin
                o_cmd.accum        = i_status.exp_done;
                o_cmd.accum_double = 1'b1;
            end
            tei_pkg::ST_MUL:        o_cmd.mul_start = 1'b1;
            tei_pkg::ST_WAIT_MUL:   ;
            tei_pkg::ST_DIV_SUM: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sum   = 1'b1;
            end
            tei_pkg::ST_WAIT_SUM:   ;
            tei_pkg::ST_FINISH:     o_cmd.out_load = i_status.out_free;
            default:                ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tei_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `TEI_ASSERT_IMP(a_exp_done_waiting, i_status.exp_done, r_state == tei_pkg::ST_WAIT_A || r_state == tei_pkg::ST_WAIT_B || r_state == tei_pkg::ST_WAIT_X, "exp result outside a wait state")
    `TEI_ASSERT_IMP(a_div_done_waiting, i_status.div_done, r_state == tei_pkg::ST_WAIT_RANGE || r_state == tei_pkg::ST_WAIT_SUM, "divider result outside a wait state")
    `TEI_ASSERT_IMP(a_mul_done_waiting, i_status.mul_done, r_state == tei_pkg::ST_WAIT_MUL, "multiplier result outside its wait state")
    `TEI_ASSERT_NEXT(a_load_starts_range, o_cmd.load, r_state == tei_pkg::ST_DIV_RANGE, "accepted request did not start")

endmodule

[hw/rtl/trapezoid_exp_integrator_top.sv]
// Each exp does its ln2 range reduction by repeated subtraction, then 14 Taylor
// steps, each through the PH_MUL, PH_RECIP and PH_CORR phases; each inner grid
// point runs the ST_CHECK, ST_STEP, ST_EXP_X and ST_WAIT_X states; two divisions
// and a shift-add multiply complete each request.
// Throughput: one request at a time; the next is taken the cycle after the result
// is loaded into a free output register.
// Reset: synchronous, active low; clears the controller and all valid/busy flags.
module trapezoid_exp_integrator_top #(
    parameter int MAX_INTERVALS = tei_pkg::MAX_INTERVALS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  tei_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output tei_pkg::t_out o_out_data
);
    tei_pkg::t_cmd    cmd;
    tei_pkg::t_status status;

    tei_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tei_dp #(
        .MAX_INTERVALS (MAX_INTERVALS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
